// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared definitions
// Screen geometry, character codes, microcode word layout and entry decode.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_SPACES = 5;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int POS_W  = $clog2(CELL_COUNT + 1);
	localparam int TAB_W  = $clog2(TAB_SPACES + 1);
	localparam int UPC_W  = 5;

	localparam int MODE_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int CURS_W  = 11;
	localparam int CELL_W  = 16;
	localparam int COLOR_W = 4;

	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CH_ESCAPE  = 8'd27;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic {
		REG_FOREGROUND = 1'b0,
		REG_BACKGROUND = 1'b1
	} reg_idx_t;

	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t UA_IDLE     = 5'd0;
	localparam upc_t UA_RD       = 5'd1;
	localparam upc_t UA_RD_EMIT  = 5'd2;
	localparam upc_t UA_CLR      = 5'd3;
	localparam upc_t UA_CLR_LOOP = 5'd4;
	localparam upc_t UA_CLR_EMIT = 5'd5;
	localparam upc_t UA_NOP      = 5'd6;
	localparam upc_t UA_NL       = 5'd7;
	localparam upc_t UA_NL_EMIT  = 5'd8;
	localparam upc_t UA_PR       = 5'd9;
	localparam upc_t UA_PR_WR    = 5'd10;
	localparam upc_t UA_PR_EMIT  = 5'd11;
	localparam upc_t UA_TB       = 5'd12;
	localparam upc_t UA_TB_WR    = 5'd13;
	localparam upc_t UA_TB_EMIT  = 5'd14;
	localparam upc_t UA_TB_END   = 5'd15;
	localparam upc_t UA_BS       = 5'd16;
	localparam upc_t UA_BS_WR    = 5'd17;
	localparam upc_t UA_BS_EMIT  = 5'd18;
	localparam upc_t UA_SC       = 5'd20;
	localparam upc_t UA_SC_RD    = 5'd21;
	localparam upc_t UA_SC_WR    = 5'd22;
	localparam upc_t UA_SC_BL    = 5'd23;
	localparam upc_t UA_SC_END   = 5'd24;

	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_RD_IDX,
		MEM_RD_SHIFT,
		MEM_WR_COPY,
		MEM_WR_BLANK,
		MEM_WR_FILL,
		MEM_WR_CHAR,
		MEM_WR_BS
	} mem_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_CLR,
		CNT_INC
	} cnt_op_t;

	typedef enum logic [2:0] {
		POS_HOLD,
		POS_ZERO,
		POS_TAIL,
		POS_INC,
		POS_DEC
	} pos_op_t;

	typedef enum logic [1:0] {
		ECHO_NONE,
		ECHO_CHAR,
		ECHO_NEWLINE,
		ECHO_SPACE
	} echo_sel_t;

	typedef enum logic [1:0] {
		LAST_NO,
		LAST_YES,
		LAST_TAB
	} last_sel_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_GOTO,
		J_CALL,
		J_RET,
		J_DONE
	} jmp_t;

	typedef enum logic [2:0] {
		C_TRUE,
		C_COPY_MORE,
		C_FILL_MORE,
		C_POS_FULL,
		C_POS_ZERO,
		C_TAB_MORE
	} cond_t;

	typedef struct packed {
		mem_op_t   mem;
		cnt_op_t   cnt;
		pos_op_t   pos;
		logic      emit;
		echo_sel_t echo;
		logic      cell_rd;
		last_sel_t last;
		logic      tab_inc;
		logic      space;
		jmp_t      jmp;
		cond_t     cond;
		upc_t      tgt;
	} uword_t;

	typedef struct packed {
		logic copy_more;
		logic fill_more;
		logic pos_full;
		logic pos_zero;
		logic tab_more;
		logic stall;
	} flags_t;

	localparam uword_t UW_NOP = '{
		mem: MEM_NONE, cnt: CNT_HOLD, pos: POS_HOLD, emit: 1'b0, echo: ECHO_NONE,
		cell_rd: 1'b0, last: LAST_NO, tab_inc: 1'b0, space: 1'b0,
		jmp: J_NEXT, cond: C_TRUE, tgt: UA_IDLE
	};

	function automatic upc_t entry_of(input logic [MODE_W-1:0] mode,
		input logic [CHAR_W-1:0] ch);
		upc_t ua;
		ua = UA_NOP;
		unique case (mode)
			MODE_READ:  ua = UA_RD;
			MODE_CLEAR: ua = UA_CLR;
			MODE_WRITE: begin
				case (ch) inside
					CH_NEWLINE, CH_RETURN: ua = UA_NL;
					CH_TAB:                ua = UA_TB;
					CH_ESCAPE:             ua = UA_BS;
					default:               ua = UA_PR;
				endcase
			end
			default: ua = UA_NOP;
		endcase
		return ua;
	endfunction

endpackage
`default_nettype wire

// File: rtl/tcw_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_if: text console writer channels
// Request, response and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, mode, char_code, cell_index, input ready);
	modport sink (input valid, mode, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CURS_W-1:0] cursor_position;
	logic [CHAR_W-1:0] echo_char;
	logic              echo_valid;
	logic [CELL_W-1:0] cell_value;
	logic              last;

	modport source (output valid, cursor_position, echo_char, echo_valid, cell_value, last,
		input ready);
	modport sink (input valid, cursor_position, echo_char, echo_valid, cell_value, last,
		output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               index;
	logic [COLOR_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/tcw_screen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_screen: screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen import tcw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [CELL_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: rtl/tcw_useq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_useq: microcode sequencer
// Control store, step counter, one-level call/return and conditional jumps.
// ----------------------------------------------------------------------------
module tcw_useq import tcw_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire upc_t   entry,
	input  wire flags_t flags,
	output uword_t      uw,
	output logic        idle
);

	upc_t upc_q;
	upc_t ret_q;
	upc_t upc_inc;
	logic taken;

	function automatic uword_t ucode(input upc_t ua);
		uword_t w;
		w = UW_NOP;
		unique case (ua)
			UA_RD:       w.mem = MEM_RD_IDX;
			UA_RD_EMIT: begin
				w.emit = 1'b1; w.cell_rd = 1'b1; w.last = LAST_YES; w.jmp = J_DONE;
			end
			UA_CLR: begin
				w.cnt = CNT_CLR; w.pos = POS_ZERO;
			end
			UA_CLR_LOOP: begin
				w.mem = MEM_WR_FILL; w.cnt = CNT_INC;
				w.jmp = J_GOTO; w.cond = C_FILL_MORE; w.tgt = UA_CLR_LOOP;
			end
			UA_CLR_EMIT, UA_NOP, UA_BS_EMIT: begin
				w.emit = 1'b1; w.last = LAST_YES; w.jmp = J_DONE;
			end
			UA_NL: begin
				w.jmp = J_CALL; w.tgt = UA_SC;
			end
			UA_NL_EMIT: begin
				w.emit = 1'b1; w.echo = ECHO_NEWLINE; w.last = LAST_YES; w.jmp = J_DONE;
			end
			UA_PR, UA_TB: begin
				w.jmp = J_CALL; w.cond = C_POS_FULL; w.tgt = UA_SC;
			end
			UA_PR_WR: begin
				w.mem = MEM_WR_CHAR; w.pos = POS_INC;
			end
			UA_PR_EMIT: begin
				w.emit = 1'b1; w.echo = ECHO_CHAR; w.last = LAST_YES; w.jmp = J_DONE;
			end
			UA_TB_WR: begin
				w.mem = MEM_WR_CHAR; w.space = 1'b1; w.pos = POS_INC;
			end
			UA_TB_EMIT: begin
				w.emit = 1'b1; w.echo = ECHO_SPACE; w.last = LAST_TAB; w.tab_inc = 1'b1;
				w.jmp = J_GOTO; w.cond = C_TAB_MORE; w.tgt = UA_TB;
			end
			UA_TB_END:   w.jmp = J_DONE;
			UA_BS: begin
				w.jmp = J_GOTO; w.cond = C_POS_ZERO; w.tgt = UA_BS_EMIT;
			end
			UA_BS_WR: begin
				w.mem = MEM_WR_BS; w.pos = POS_DEC;
			end
			UA_SC:       w.cnt = CNT_CLR;
			UA_SC_RD:    w.mem = MEM_RD_SHIFT;
			UA_SC_WR: begin
				w.mem = MEM_WR_COPY; w.cnt = CNT_INC;
				w.jmp = J_GOTO; w.cond = C_COPY_MORE; w.tgt = UA_SC_RD;
			end
			UA_SC_BL: begin
				w.mem = MEM_WR_BLANK; w.cnt = CNT_INC;
				w.jmp = J_GOTO; w.cond = C_FILL_MORE; w.tgt = UA_SC_BL;
			end
			UA_SC_END: begin
				w.pos = POS_TAIL; w.jmp = J_RET;
			end
			default:     w = UW_NOP;
		endcase
		return w;
	endfunction

	assign uw      = ucode(upc_q);
	assign idle    = (upc_q == UA_IDLE);
	assign upc_inc = upc_q + UPC_W'(1);

	always_comb begin
		unique case (uw.cond)
			C_TRUE:      taken = 1'b1;
			C_COPY_MORE: taken = flags.copy_more;
			C_FILL_MORE: taken = flags.fill_more;
			C_POS_FULL:  taken = flags.pos_full;
			C_POS_ZERO:  taken = flags.pos_zero;
			C_TAB_MORE:  taken = flags.tab_more;
			default:     taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
			ret_q <= UA_IDLE;
		end else if (idle) begin
			if (start) begin
				upc_q <= entry;
			end
		end else if (!flags.stall) begin
			unique case (uw.jmp)
				J_NEXT: upc_q <= upc_inc;
				J_GOTO: upc_q <= taken ? uw.tgt : upc_inc;
				J_CALL: begin
					if (taken) begin
						ret_q <= upc_inc;
						upc_q <= uw.tgt;
					end else begin
						upc_q <= upc_inc;
					end
				end
				J_RET:  upc_q <= ret_q;
				J_DONE: upc_q <= UA_IDLE;
				default: upc_q <= UA_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/text_console_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_core: 80x25 text cell console writer
// Keeps the screen cells and write position; answers each request with one
// result (five for a tab) echoing the serial byte and the cursor.
// ----------------------------------------------------------------------------
// Usage:
//   req  carries mode, char_code and cell_index; one transfer per request.
//   rsp  carries cursor_position, echo_char, echo_valid, cell_value and last;
//        last marks the final result of a request.
//   cfg  writes foreground (index 0) and background (index 1) colour; it is
//        always ready; write it only while no request is in flight, which
//        the block itself does not enforce.
// Scrolling: a newline always scrolls the screen, and a printable byte or tab
//   space at the screen end scrolls it before being stored. The scroll moves
//   cells through the single read and single write port of the screen RAM.
// One request is worked at a time by the microcode sequencer.
// Results sit in an output register; a stalled receiver holds the sequencer
// at its emit step until the register is taken.
// Reset puts the position at zero and colours at white on black; screen
// contents are undefined until written, there is no clearing pass.
// ----------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	tcw_req_if.sink  req,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink  cfg
);

	logic [MODE_W-1:0]  mode_q;
	logic [CHAR_W-1:0]  chr_q;
	logic [IDX_W-1:0]   idx_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   cnt_q;
	logic [TAB_W-1:0]   tab_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;

	logic               rsp_valid_q;
	logic [CURS_W-1:0]  cursor_q;
	logic [CHAR_W-1:0]  echo_char_q;
	logic               echo_valid_q;
	logic [CELL_W-1:0]  cell_q;
	logic               last_q;

	uword_t             uw;
	flags_t             flags;
	logic               idle;
	logic               accept;
	logic               go;
	logic               load;
	logic               idx_oob;
	logic               tab_last;
	logic [7:0]         attr;

	logic               we;
	logic               re;
	logic [ADDR_W-1:0]  waddr;
	logic [ADDR_W-1:0]  raddr;
	logic [CELL_W-1:0]  wdata;
	logic [CELL_W-1:0]  rdata;
	logic [CHAR_W-1:0]  wchar;
	logic [CHAR_W-1:0]  echo_d;
	logic [POS_W-1:0]   pos_m1;
	logic [POS_W-1:0]   shift_addr;

	assign accept    = req.valid && req.ready;
	assign req.ready = idle;
	assign cfg.ready = 1'b1;
	assign attr      = {bg_q, fg_q};
	assign idx_oob   = (32'(idx_q) >= 32'(CELL_COUNT));
	assign tab_last  = (tab_q == TAB_W'(TAB_SPACES - 1));
	assign pos_m1    = pos_q - POS_W'(1);
	assign shift_addr = cnt_q + POS_W'(COLUMNS);

	assign flags.copy_more = (cnt_q != POS_W'(COPY_COUNT - 1));
	assign flags.fill_more = (cnt_q != POS_W'(CELL_COUNT - 1));
	assign flags.pos_full  = (pos_q == POS_W'(CELL_COUNT));
	assign flags.pos_zero  = (pos_q == '0);
	assign flags.tab_more  = !tab_last;
	assign flags.stall     = uw.emit && rsp_valid_q && !rsp.ready;

	assign go   = !flags.stall;
	assign load = uw.emit && go;

	tcw_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.entry  (entry_of(req.mode, req.char_code)),
		.flags  (flags),
		.uw     (uw),
		.idle   (idle)
	);

	assign wchar = uw.space ? CH_SPACE : chr_q;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = cnt_q[ADDR_W-1:0];
		raddr = shift_addr[ADDR_W-1:0];
		wdata = BLANK_CELL;
		case (uw.mem)
			MEM_RD_IDX: begin
				re    = go && !idx_oob;
				raddr = ADDR_W'(idx_q);
			end
			MEM_RD_SHIFT: re = go;
			MEM_WR_COPY: begin
				we    = go;
				wdata = rdata;
			end
			MEM_WR_BLANK: we = go;
			MEM_WR_FILL: begin
				we    = go;
				wdata = {attr, 8'h00};
			end
			MEM_WR_CHAR: begin
				we    = go;
				waddr = pos_q[ADDR_W-1:0];
				wdata = {attr, wchar};
			end
			MEM_WR_BS: begin
				we    = go;
				waddr = pos_m1[ADDR_W-1:0];
			end
			default: we = 1'b0;
		endcase
	end

	tcw_screen u_screen (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		case (uw.echo)
			ECHO_CHAR:    echo_d = chr_q;
			ECHO_NEWLINE: echo_d = CH_NEWLINE;
			ECHO_SPACE:   echo_d = CH_SPACE;
			default:      echo_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
			tab_q <= '0;
			fg_q  <= 4'd15;
			bg_q  <= 4'd0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (reg_idx_t'(cfg.index))
					REG_FOREGROUND: fg_q <= cfg.data;
					REG_BACKGROUND: bg_q <= cfg.data;
				endcase
			end
			if (accept) begin
				tab_q <= '0;
			end else if (go && uw.tab_inc) begin
				tab_q <= tab_q + TAB_W'(1);
			end
			if (go) begin
				case (uw.cnt)
					CNT_CLR: cnt_q <= '0;
					CNT_INC: cnt_q <= cnt_q + POS_W'(1);
					default: cnt_q <= cnt_q;
				endcase
				case (uw.pos)
					POS_ZERO: pos_q <= '0;
					POS_TAIL: pos_q <= POS_W'(COPY_COUNT);
					POS_INC:  pos_q <= pos_q + POS_W'(1);
					POS_DEC:  pos_q <= pos_m1;
					default:  pos_q <= pos_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			chr_q  <= req.char_code;
			idx_q  <= req.cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cursor_q     <= CURS_W'(pos_q);
			echo_char_q  <= echo_d;
			echo_valid_q <= (uw.echo != ECHO_NONE);
			cell_q       <= (uw.cell_rd && !idx_oob && mode_q == MODE_READ) ? rdata : '0;
			last_q       <= (uw.last == LAST_YES) || (uw.last == LAST_TAB && tab_last);
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.cursor_position = cursor_q;
	assign rsp.echo_char       = echo_char_q;
	assign rsp.echo_valid      = echo_valid_q;
	assign rsp.cell_value      = cell_q;
	assign rsp.last            = last_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(CELL_COUNT))
		else $error("write position beyond screen");

	a_char_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(we && uw.mem == MEM_WR_CHAR) |-> (pos_q < POS_W'(CELL_COUNT)))
		else $error("character stored at screen end without scroll");

	a_bs_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(we && uw.mem == MEM_WR_BS) |-> !flags.pos_zero)
		else $error("backspace store at position zero");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while previous one in flight");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: text console writer core testbench
// Sends console requests and colour writes over the channels, tracks a shadow
// screen, cursor and colour pair, and checks every result in arrival order.
// Directed tests cover the special characters, reads, clear and the screen
// end; random phases follow, with stalls on both sides in all but the last one.
// ----------------------------------------------------------------------------
module tb_top;
	import tcw_pkg::*;

	localparam logic [MODE_W-1:0]  MODE_UNUSED   = 2'd3;
	localparam logic [CHAR_W-1:0]  NO_ECHO       = '0;
	localparam logic [CHAR_W-1:0]  FILL_CHAR     = '0;
	localparam logic [COLOR_W-1:0] RESET_FG      = 4'hF;
	localparam logic [COLOR_W-1:0] RESET_BG      = 4'h0;
	localparam logic [COLOR_W-1:0] COLOR_MIN     = 4'h0;
	localparam logic [COLOR_W-1:0] COLOR_MAX     = 4'hF;
	localparam int                 IDX_MAX       = (1 << IDX_W) - 1;
	localparam int                 QUIET_LIMIT   = 20000;
	localparam int                 SETTLE_CYCLES = 8;
	localparam int                 DRAIN_CYCLES  = 20;

	typedef struct {
		logic [CURS_W-1:0] cursor_position;
		logic [CHAR_W-1:0] echo_char;
		logic              echo_valid;
		logic [CELL_W-1:0] cell_value;
		logic              last;
	} console_result_t;

	logic clk;
	logic arst_n;
	bit   idle_on;
	int   error_count = 0;
	int   quiet_cycles = 0;

	logic [CELL_W-1:0]  screen_shadow [CELL_COUNT];
	logic [POS_W-1:0]   cursor_shadow;
	logic [COLOR_W-1:0] fg_shadow;
	logic [COLOR_W-1:0] bg_shadow;
	console_result_t    result_q [$];

	tcw_req_if req_ch ();
	tcw_rsp_if rsp_ch ();
	tcw_cfg_if cfg_ch ();

	text_console_writer_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void queue_result(input logic [CHAR_W-1:0] echo, input logic echo_ok,
		input logic [CELL_W-1:0] cell_word, input logic is_last);
		console_result_t r;
		r.cursor_position = cursor_shadow[CURS_W-1:0];
		r.echo_char       = echo;
		r.echo_valid      = echo_ok;
		r.cell_value      = cell_word;
		r.last            = is_last;
		result_q.push_back(r);
	endfunction

	function automatic void scroll_shadow();
		for (int i = 0; i < COPY_COUNT; i++)
			screen_shadow[i] = screen_shadow[i + COLUMNS];
		for (int i = COPY_COUNT; i < CELL_COUNT; i++)
			screen_shadow[i] = BLANK_CELL;
		cursor_shadow = POS_W'(COPY_COUNT);
	endfunction

	function automatic void store_char(input logic [CHAR_W-1:0] ch);
		if (cursor_shadow >= CELL_COUNT)
			scroll_shadow();
		screen_shadow[cursor_shadow] = {bg_shadow, fg_shadow, ch};
		cursor_shadow = cursor_shadow + 1'b1;
	endfunction

	function automatic void predict_console(input logic [MODE_W-1:0] mode,
		input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx);
		logic [CELL_W-1:0] cell_word;
		cell_word = '0;
		case (mode)
			MODE_READ: begin
				if (idx < CELL_COUNT)
					cell_word = screen_shadow[idx];
				queue_result(NO_ECHO, 1'b0, cell_word, 1'b1);
			end
			MODE_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					screen_shadow[i] = {bg_shadow, fg_shadow, FILL_CHAR};
				cursor_shadow = '0;
				queue_result(NO_ECHO, 1'b0, cell_word, 1'b1);
			end
			MODE_WRITE: begin
				case (ch)
					CH_NEWLINE, CH_RETURN: begin
						scroll_shadow();
						queue_result(CH_NEWLINE, 1'b1, cell_word, 1'b1);
					end
					CH_TAB: begin
						for (int t = 0; t < TAB_SPACES; t++) begin
							store_char(CH_SPACE);
							queue_result(CH_SPACE, 1'b1, cell_word, t == TAB_SPACES - 1);
						end
					end
					CH_ESCAPE: begin
						if (cursor_shadow != 0) begin
							cursor_shadow = cursor_shadow - 1'b1;
							screen_shadow[cursor_shadow] = BLANK_CELL;
						end
						queue_result(NO_ECHO, 1'b0, cell_word, 1'b1);
					end
					default: begin
						store_char(ch);
						queue_result(ch, 1'b1, cell_word, 1'b1);
					end
				endcase
			end
			default: queue_result(NO_ECHO, 1'b0, cell_word, 1'b1);
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [CELL_W-1:0] want,
		input logic [CELL_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endfunction

	task automatic send_request(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
		input logic [IDX_W-1:0] idx);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= mode;
		req_ch.char_code  <= ch;
		req_ch.cell_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		predict_console(mode, ch, idx);
	endtask

	task automatic write_color(input reg_idx_t which, input logic [COLOR_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= which;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (which == REG_FOREGROUND)
			fg_shadow = value;
		else
			bg_shadow = value;
	endtask

	task automatic test_unused_mode();
		send_request(MODE_UNUSED, 8'hFF, IDX_W'(IDX_MAX));
	endtask

	task automatic test_clear_and_read();
		send_request(MODE_CLEAR, '0, '0);
		send_request(MODE_READ, '0, '0);
		send_request(MODE_READ, '0, IDX_W'(CELL_COUNT - 1));
		send_request(MODE_READ, 8'hFF, IDX_W'(IDX_MAX));
	endtask

	task automatic test_printable_extremes();
		write_color(REG_FOREGROUND, 4'hA);
		write_color(REG_BACKGROUND, 4'h5);
		send_request(MODE_WRITE, 8'h00, IDX_W'(IDX_MAX));
		send_request(MODE_WRITE, 8'hFF, '0);
		send_request(MODE_READ, '0, IDX_W'(1));
	endtask

	task automatic test_backspace();
		repeat (3) send_request(MODE_WRITE, CH_ESCAPE, '0);
		send_request(MODE_READ, '0, '0);
	endtask

	task automatic test_scroll();
		send_request(MODE_WRITE, CH_RETURN, '0);
		send_request(MODE_WRITE, CH_NEWLINE, '0);
	endtask

	task automatic test_screen_end();
		repeat (CELL_COUNT / TAB_SPACES - COPY_COUNT / TAB_SPACES)
			send_request(MODE_WRITE, CH_TAB, '0);
		send_request(MODE_WRITE, 8'h7E, '0);
		send_request(MODE_READ, '0, IDX_W'(COPY_COUNT - 1));
	endtask

	task automatic run_random_phase(input int count, input int newline_pct,
		input int clear_pct);
		int                roll;
		logic [MODE_W-1:0] mode;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			mode = MODE_WRITE;
			ch   = CHAR_W'($urandom_range(0, 255));
			idx  = IDX_W'($urandom_range(0, IDX_MAX));
			if (roll < 14) begin
				mode = MODE_READ;
				case ($urandom_range(0, 9))
					0:       idx = IDX_W'($urandom_range(CELL_COUNT, IDX_MAX));
					1, 2, 3: idx = (cursor_shadow == 0) ? '0 : cursor_shadow - 1'b1;
					default: idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
				endcase
			end else if (roll < 16)
				mode = MODE_UNUSED;
			else if (roll < 16 + clear_pct)
				mode = MODE_CLEAR;
			else if (roll < 22 + clear_pct)
				ch = CH_ESCAPE;
			else if (roll < 28 + clear_pct)
				ch = CH_TAB;
			else if (roll < 28 + clear_pct + newline_pct)
				ch = $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN;
			send_request(mode, ch, idx);
		end
	endtask

	task automatic test_random_mixed();
		write_color(REG_FOREGROUND, COLOR_MIN);
		write_color(REG_BACKGROUND, COLOR_MAX);
		run_random_phase(80, 8, 2);
	endtask

	task automatic test_random_lines();
		write_color(REG_FOREGROUND, COLOR_W'($urandom_range(0, 15)));
		write_color(REG_BACKGROUND, COLOR_W'($urandom_range(0, 15)));
		send_request(MODE_WRITE, CH_NEWLINE, '0);
		run_random_phase(80, 2, 0);
	endtask

	task automatic test_random_steady();
		write_color(REG_FOREGROUND, COLOR_MAX);
		write_color(REG_BACKGROUND, COLOR_MIN);
		idle_on = 1'b0;
		run_random_phase(90, 6, 2);
	endtask

	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		console_result_t want;
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (result_q.size() == 0) begin
					$error("result with nothing pending: cursor_position %0d",
						rsp_ch.cursor_position);
					error_count++;
				end else begin
					want = result_q.pop_front();
					check_field("cursor_position", CELL_W'(want.cursor_position),
						CELL_W'(rsp_ch.cursor_position));
					check_field("echo_char", CELL_W'(want.echo_char),
						CELL_W'(rsp_ch.echo_char));
					check_field("echo_valid", CELL_W'(want.echo_valid),
						CELL_W'(rsp_ch.echo_valid));
					check_field("cell_value", want.cell_value, rsp_ch.cell_value);
					check_field("last", CELL_W'(want.last), CELL_W'(rsp_ch.last));
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n            <= 1'b0;
		idle_on            = 1'b1;
		cursor_shadow      = '0;
		fg_shadow          = RESET_FG;
		bg_shadow          = RESET_BG;
		req_ch.valid      <= 1'b0;
		req_ch.mode       <= MODE_WRITE;
		req_ch.char_code  <= '0;
		req_ch.cell_index <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_FOREGROUND;
		cfg_ch.data       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unused_mode();
		test_clear_and_read();
		test_printable_extremes();
		test_backspace();
		test_scroll();
		test_screen_end();
		test_random_mixed();
		test_random_lines();
		test_random_steady();

		req_ch.valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// File: text_console_writer_core.f
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_screen.sv
rtl/tcw_useq.sv
rtl/text_console_writer_core.sv
tb/sv/tb_top.sv
